>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MFCE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MFCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mfce_pkg.sv
// ----------------------------------------------------------------------------
// mfce_pkg
// Constants, types and face tables of the mesh face centroid engine.
// ----------------------------------------------------------------------------
package mfce_pkg;

   localparam int VERTEX_DEPTH = 65536;
   localparam int VERTEX_AW    = $clog2(VERTEX_DEPTH);
   localparam int COORD_WIDTH  = 32;
   localparam int COORD_W      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int FIELD_W      = 32;
   localparam int INDEX_W      = 16;
   localparam int COUNT_W      = 32;
   localparam int PAIR_W       = COORD_W + 1;
   localparam int SUM_W        = COORD_W + 2;

   localparam int NUM_AXES    = 3;
   localparam int NUM_CORNERS = 8;
   localparam int NUM_PAIRS   = 4;

   // Divide by three: one radix-16 digit per step, several steps per stage.
   localparam int DIV_STAGES       = 3;
   localparam int DIGITS           = (SUM_W + 3) / 4;
   localparam int DIGITS_PER_STAGE = (DIGITS + DIV_STAGES - 1) / DIV_STAGES;
   localparam int MAG_W            = DIV_STAGES * DIGITS_PER_STAGE * 4;
   localparam int AXIS_LATENCY     = DIV_STAGES + 2;

   // floor(v / 3) == (v * ONE_THIRD_MUL) >> ONE_THIRD_SHIFT for v < 128
   localparam int ONE_THIRD_MUL    = 43;
   localparam int ONE_THIRD_SHIFT  = 7;
   localparam int ONE_FOURTH_SHIFT = 2;

   typedef logic [VERTEX_AW-1:0]      vaddr_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PAIR_W-1:0]  pair_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic [MAG_W-1:0]          mag_type;
   typedef logic [FIELD_W-1:0]        field_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [2:0]                etype_type;
   typedef logic [2:0]                slot_type;

   localparam logic [1:0] ACT_LOAD_X  = 2'd0;
   localparam logic [1:0] ACT_LOAD_Y  = 2'd1;
   localparam logic [1:0] ACT_LOAD_Z  = 2'd2;
   localparam logic [1:0] ACT_ELEMENT = 2'd3;

   localparam etype_type ETYPE_TRI   = 3'd0;
   localparam etype_type ETYPE_QUAD  = 3'd1;
   localparam etype_type ETYPE_TETRA = 3'd2;
   localparam etype_type ETYPE_PYRA  = 3'd3;
   localparam etype_type ETYPE_HEXA  = 3'd4;
   localparam etype_type ETYPE_PENTA = 3'd5;

   typedef struct packed {
      logic [NUM_CORNERS-1:0] mask;
      logic                   quad;
   } face_info_type;

   // Index of the last corner an element type reads.
   function automatic slot_type corner_last(input etype_type etype);
      case (etype)
         ETYPE_TRI:   return 3'd2;
         ETYPE_QUAD:  return 3'd3;
         ETYPE_TETRA: return 3'd3;
         ETYPE_PYRA:  return 3'd4;
         ETYPE_HEXA:  return 3'd7;
         ETYPE_PENTA: return 3'd5;
         default:     return 3'd0;
      endcase
   endfunction

   // Index of the last face of an element type.
   function automatic slot_type face_last(input etype_type etype);
      case (etype)
         ETYPE_TRI:   return 3'd0;
         ETYPE_QUAD:  return 3'd0;
         ETYPE_TETRA: return 3'd3;
         ETYPE_PYRA:  return 3'd4;
         ETYPE_HEXA:  return 3'd5;
         ETYPE_PENTA: return 3'd4;
         default:     return 3'd0;
      endcase
   endfunction

   // Corner set of one face, as a mask over the eight corners, and whether it is a quad.
   function automatic face_info_type face_info(input etype_type etype, input slot_type fidx);
      logic [NUM_CORNERS-1:0] mask;
      logic [3:0]             cnt;
      face_info_type          info;
      mask = '0;
      case (etype)
         ETYPE_TRI:  mask = 8'h07;
         ETYPE_QUAD: mask = 8'h0F;
         ETYPE_TETRA: begin
            case (fidx)
               3'd0:    mask = 8'h07;
               3'd1:    mask = 8'h0B;
               3'd2:    mask = 8'h0E;
               3'd3:    mask = 8'h0D;
               default: mask = '0;
            endcase
         end
         ETYPE_PYRA: begin
            case (fidx)
               3'd0:    mask = 8'h0F;
               3'd1:    mask = 8'h13;
               3'd2:    mask = 8'h16;
               3'd3:    mask = 8'h1C;
               3'd4:    mask = 8'h19;
               default: mask = '0;
            endcase
         end
         ETYPE_HEXA: begin
            case (fidx)
               3'd0:    mask = 8'h0F;
               3'd1:    mask = 8'hF0;
               3'd2:    mask = 8'h99;
               3'd3:    mask = 8'h66;
               3'd4:    mask = 8'h33;
               3'd5:    mask = 8'hCC;
               default: mask = '0;
            endcase
         end
         ETYPE_PENTA: begin
            case (fidx)
               3'd0:    mask = 8'h07;
               3'd1:    mask = 8'h38;
               3'd2:    mask = 8'h1B;
               3'd3:    mask = 8'h36;
               3'd4:    mask = 8'h2D;
               default: mask = '0;
            endcase
         end
         default: mask = '0;
      endcase
      cnt = '0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         cnt = cnt + {3'b000, mask[i]};
      end
      info.mask = mask;
      info.quad = (cnt == 4'd4);
      return info;
   endfunction

endpackage

>>> rtl/mfce_vertex_ram.sv
// ----------------------------------------------------------------------------
// mfce_vertex_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mfce_vertex_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= write_data;
      end
      read_data_ff <= mem[addr];
   end

   assign read_data = read_data_ff;

endmodule

>>> rtl/mfce_axis_div.sv
// ----------------------------------------------------------------------------
// mfce_axis_div
// One axis of the centroid datapath: adds the four pair sums of a face and
// divides by three or four, truncating toward zero.
// ----------------------------------------------------------------------------
module mfce_axis_div (
   input  logic                 clock,
   input  logic                 advance,
   input  mfce_pkg::pair_type   pair_sum [mfce_pkg::NUM_PAIRS],
   input  logic                 quad_face,
   output mfce_pkg::field_type  center
);

   mfce_pkg::sum_type sum_ff, sum_in;
   logic              quad_s_ff;

   // index 0 is the magnitude stage, 1..DIV_STAGES the digit stages
   mfce_pkg::mag_type mag_ff  [mfce_pkg::DIV_STAGES+1];
   mfce_pkg::mag_type mag_in  [mfce_pkg::DIV_STAGES+1];
   mfce_pkg::mag_type quot_ff [mfce_pkg::DIV_STAGES+1];
   mfce_pkg::mag_type quot_in [mfce_pkg::DIV_STAGES+1];
   logic [1:0]        rem_ff  [mfce_pkg::DIV_STAGES+1];
   logic [1:0]        rem_in  [mfce_pkg::DIV_STAGES+1];
   logic              neg_ff  [mfce_pkg::DIV_STAGES+1];
   logic              neg_in  [mfce_pkg::DIV_STAGES+1];
   logic              quad_ff [mfce_pkg::DIV_STAGES+1];
   logic              quad_in [mfce_pkg::DIV_STAGES+1];

   logic [mfce_pkg::SUM_W-1:0] abs_sum;
   mfce_pkg::mag_type          result;

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < mfce_pkg::NUM_PAIRS; j++) begin
         sum_in = sum_in + mfce_pkg::sum_type'(pair_sum[j]);
      end
   end

   // Magnitude stage; a quad face is finished here by a shift.
   always_comb begin
      abs_sum    = sum_ff[mfce_pkg::SUM_W-1] ? mfce_pkg::SUM_W'(-sum_ff)
                                             : mfce_pkg::SUM_W'(sum_ff);
      mag_in[0]  = mfce_pkg::mag_type'(abs_sum);
      quot_in[0] = quad_s_ff ? mfce_pkg::mag_type'(abs_sum >> mfce_pkg::ONE_FOURTH_SHIFT)
                             : '0;
      rem_in[0]  = 2'b00;
      neg_in[0]  = sum_ff[mfce_pkg::SUM_W-1];
      quad_in[0] = quad_s_ff;
   end

   for (genvar s = 1; s <= mfce_pkg::DIV_STAGES; s++) begin : g_stage
      always_comb begin : digit_steps
         mfce_pkg::mag_type m;
         mfce_pkg::mag_type q;
         logic [1:0]        r;
         logic [5:0]        v;
         logic [12:0]       prod;
         logic [3:0]        qd;
         logic [5:0]        rfull;
         m = mag_ff[s-1];
         q = quot_ff[s-1];
         r = rem_ff[s-1];
         for (int i = 0; i < mfce_pkg::DIGITS_PER_STAGE; i++) begin
            v     = {r, m[mfce_pkg::MAG_W-1 -: 4]};
            prod  = 13'(v) * 13'(mfce_pkg::ONE_THIRD_MUL);
            qd    = 4'(prod >> mfce_pkg::ONE_THIRD_SHIFT);
            rfull = v - 6'({2'b00, qd} * 6'd3);
            r     = rfull[1:0];
            m     = {m[mfce_pkg::MAG_W-5:0], 4'b0000};
            q     = {q[mfce_pkg::MAG_W-5:0], qd};
         end
         // quad faces pass straight through
         mag_in[s]  = quad_ff[s-1] ? mag_ff[s-1]  : m;
         quot_in[s] = quad_ff[s-1] ? quot_ff[s-1] : q;
         rem_in[s]  = quad_ff[s-1] ? rem_ff[s-1]  : r;
         neg_in[s]  = neg_ff[s-1];
         quad_in[s] = quad_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff    <= sum_in;
         quad_s_ff <= quad_face;
         for (int k = 0; k <= mfce_pkg::DIV_STAGES; k++) begin
            mag_ff[k]  <= mag_in[k];
            quot_ff[k] <= quot_in[k];
            rem_ff[k]  <= rem_in[k];
            neg_ff[k]  <= neg_in[k];
            quad_ff[k] <= quad_in[k];
         end
      end
   end

   // Restore sign, keep coordinate width, sign-extend to the field.
   always_comb begin
      result = neg_ff[mfce_pkg::DIV_STAGES] ? -quot_ff[mfce_pkg::DIV_STAGES]
                                           : quot_ff[mfce_pkg::DIV_STAGES];
      center = mfce_pkg::field_type'(mfce_pkg::coord_type'(result[mfce_pkg::COORD_W-1:0]));
   end

endmodule

>>> rtl/mesh_face_centroid_engine_unit.sv
// ----------------------------------------------------------------------------
// mesh_face_centroid_engine_unit
// Face centroids of unstructured mesh elements from stored vertex coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: a load word (action x, y or z) writes coord_value into the
//   vertex store of that axis at vertex_address and gives no result. An
//   element word reads its corners from the stores and then gives one rsp
//   word per face in the fixed face order of its type.
//   Faces leave one per cycle while the rsp channel is not stalled.
//   An element holds req_ready low through its corner reads, a settle state
//   and its face issue, set by the single port of the vertex stores, read
//   once per corner, and by the face issue of one face per cycle while the
//   rsp channel is not stalled. Unknown element types are taken and dropped.
//   Reset clears the face counter and all valid flags; vertex stores keep
//   whatever they hold and must be loaded before use.
//   A stalled rsp channel freezes the face pipeline; a finished result waits
//   in the output register, and new words are still taken while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mesh_face_centroid_engine_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_element_type,
   input  logic [15:0] req_vertex_address,
   input  logic [31:0] req_coord_value,
   input  logic [15:0] req_corner_a,
   input  logic [15:0] req_corner_b,
   input  logic [15:0] req_corner_c,
   input  logic [15:0] req_corner_d,
   input  logic [15:0] req_corner_e,
   input  logic [15:0] req_corner_f,
   input  logic [15:0] req_corner_g,
   input  logic [15:0] req_corner_h,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_center_x,
   output logic [31:0] rsp_center_y,
   output logic [31:0] rsp_center_z,
   output logic [31:0] rsp_face_number,
   output logic        rsp_last_face
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SETTLE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic                 req_fire, load_fire, elem_fire, advance, emit;
   mfce_pkg::slot_type   rd_idx_ff, rd_idx_in;
   mfce_pkg::slot_type   cap_idx_ff, cap_idx_in;
   logic                 cap_valid_ff, cap_valid_in;
   mfce_pkg::slot_type   face_idx_ff, face_idx_in;
   mfce_pkg::count_type  face_counter_ff, face_counter_in;
   logic                 p_valid_ff, p_valid_in;
   logic [mfce_pkg::AXIS_LATENCY-1:0] pipe_valid_ff, pipe_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   mfce_pkg::etype_type  etype_ff;
   mfce_pkg::vaddr_type  corner_ff [mfce_pkg::NUM_CORNERS];
   mfce_pkg::coord_type  coord_ff [mfce_pkg::NUM_AXES][mfce_pkg::NUM_CORNERS];
   mfce_pkg::pair_type   pair_in [mfce_pkg::NUM_AXES][mfce_pkg::NUM_PAIRS];
   mfce_pkg::pair_type   pair_ff [mfce_pkg::NUM_AXES][mfce_pkg::NUM_PAIRS];
   mfce_pkg::face_info_type info;
   mfce_pkg::count_type  p_face_ff;
   logic                 p_last_ff;
   logic                 p_quad_ff;
   mfce_pkg::count_type  pipe_face_ff [mfce_pkg::AXIS_LATENCY];
   logic [mfce_pkg::AXIS_LATENCY-1:0] pipe_last_ff;

   logic [mfce_pkg::NUM_AXES-1:0] ram_we;
   mfce_pkg::vaddr_type  ram_addr;
   logic [mfce_pkg::COORD_W-1:0] ram_rdata [mfce_pkg::NUM_AXES];
   mfce_pkg::field_type  center [mfce_pkg::NUM_AXES];

   mfce_pkg::field_type  rsp_center_x_ff, rsp_center_y_ff, rsp_center_z_ff;
   mfce_pkg::count_type  rsp_face_ff;
   logic                 rsp_last_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign load_fire = req_fire & (req_action != mfce_pkg::ACT_ELEMENT);
   assign elem_fire = req_fire & (req_action == mfce_pkg::ACT_ELEMENT)
                    & (req_element_type <= mfce_pkg::ETYPE_PENTA);
   assign advance   = !rsp_valid_ff | rsp_ready;
   assign emit      = (state_ff == ST_EMIT) & advance;

   // ---------------------------------------------------------------- stores
   always_comb begin
      ram_we[0] = load_fire & (req_action == mfce_pkg::ACT_LOAD_X);
      ram_we[1] = load_fire & (req_action == mfce_pkg::ACT_LOAD_Y);
      ram_we[2] = load_fire & (req_action == mfce_pkg::ACT_LOAD_Z);
      ram_addr  = (state_ff == ST_IDLE) ? mfce_pkg::vaddr_type'(req_vertex_address)
                                        : corner_ff[rd_idx_ff];
   end

   for (genvar a = 0; a < mfce_pkg::NUM_AXES; a++) begin : g_axis
      mfce_vertex_ram #(
         .DEPTH (mfce_pkg::VERTEX_DEPTH),
         .WIDTH (mfce_pkg::COORD_W)
      ) u_store (
         .clock      (clock),
         .write_en   (ram_we[a]),
         .addr       (ram_addr),
         .write_data (req_coord_value[mfce_pkg::COORD_W-1:0]),
         .read_data  (ram_rdata[a])
      );

      mfce_axis_div u_div (
         .clock     (clock),
         .advance   (advance),
         .pair_sum  (pair_ff[a]),
         .quad_face (p_quad_ff),
         .center    (center[a])
      );
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in        = state_ff;
      rd_idx_in       = rd_idx_ff;
      face_idx_in     = face_idx_ff;
      face_counter_in = face_counter_ff;
      cap_valid_in    = (state_ff == ST_READ);
      cap_idx_in      = rd_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (elem_fire) begin
               state_in    = ST_READ;
               rd_idx_in   = '0;
               face_idx_in = '0;
            end
         end
         ST_READ: begin
            if (rd_idx_ff == mfce_pkg::corner_last(etype_ff)) begin
               state_in = ST_SETTLE;
            end else begin
               rd_idx_in = rd_idx_ff + 3'd1;
            end
         end
         ST_SETTLE: begin
            // last corner lands this cycle
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (advance) begin
               face_counter_in = face_counter_ff + 32'd1;
               face_idx_in     = face_idx_ff + 3'd1;
               if (face_idx_ff == mfce_pkg::face_last(etype_ff)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      p_valid_in    = advance ? emit : p_valid_ff;
      pipe_valid_in = advance ? {pipe_valid_ff[mfce_pkg::AXIS_LATENCY-2:0], p_valid_ff}
                              : pipe_valid_ff;
      rsp_valid_in  = advance ? pipe_valid_ff[mfce_pkg::AXIS_LATENCY-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rd_idx_ff       <= '0;
         cap_idx_ff      <= '0;
         cap_valid_ff    <= 1'b0;
         face_idx_ff     <= '0;
         face_counter_ff <= '0;
         p_valid_ff      <= 1'b0;
         pipe_valid_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rd_idx_ff       <= rd_idx_in;
         cap_idx_ff      <= cap_idx_in;
         cap_valid_ff    <= cap_valid_in;
         face_idx_ff     <= face_idx_in;
         face_counter_ff <= face_counter_in;
         p_valid_ff      <= p_valid_in;
         pipe_valid_ff   <= pipe_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- face sums
   always_comb begin
      info = mfce_pkg::face_info(etype_ff, face_idx_ff);
      for (int a = 0; a < mfce_pkg::NUM_AXES; a++) begin
         for (int j = 0; j < mfce_pkg::NUM_PAIRS; j++) begin
            pair_in[a][j] =
               (info.mask[2*j]   ? mfce_pkg::pair_type'(coord_ff[a][2*j])   : '0) +
               (info.mask[2*j+1] ? mfce_pkg::pair_type'(coord_ff[a][2*j+1]) : '0);
         end
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (elem_fire) begin
         etype_ff     <= req_element_type;
         corner_ff[0] <= mfce_pkg::vaddr_type'(req_corner_a);
         corner_ff[1] <= mfce_pkg::vaddr_type'(req_corner_b);
         corner_ff[2] <= mfce_pkg::vaddr_type'(req_corner_c);
         corner_ff[3] <= mfce_pkg::vaddr_type'(req_corner_d);
         corner_ff[4] <= mfce_pkg::vaddr_type'(req_corner_e);
         corner_ff[5] <= mfce_pkg::vaddr_type'(req_corner_f);
         corner_ff[6] <= mfce_pkg::vaddr_type'(req_corner_g);
         corner_ff[7] <= mfce_pkg::vaddr_type'(req_corner_h);
      end
      if (cap_valid_ff) begin
         for (int a = 0; a < mfce_pkg::NUM_AXES; a++) begin
            coord_ff[a][cap_idx_ff] <= mfce_pkg::coord_type'(ram_rdata[a]);
         end
      end
      if (emit) begin
         pair_ff   <= pair_in;
         p_face_ff <= face_counter_ff;
         p_last_ff <= (face_idx_ff == mfce_pkg::face_last(etype_ff));
         p_quad_ff <= info.quad;
      end
      if (advance) begin
         pipe_face_ff[0] <= p_face_ff;
         for (int k = 1; k < mfce_pkg::AXIS_LATENCY; k++) begin
            pipe_face_ff[k] <= pipe_face_ff[k-1];
         end
         pipe_last_ff    <= {pipe_last_ff[mfce_pkg::AXIS_LATENCY-2:0], p_last_ff};
         rsp_center_x_ff <= center[0];
         rsp_center_y_ff <= center[1];
         rsp_center_z_ff <= center[2];
         rsp_face_ff     <= pipe_face_ff[mfce_pkg::AXIS_LATENCY-1];
         rsp_last_ff     <= pipe_last_ff[mfce_pkg::AXIS_LATENCY-1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_center_x    = rsp_center_x_ff;
   assign rsp_center_y    = rsp_center_y_ff;
   assign rsp_center_z    = rsp_center_z_ff;
   assign rsp_face_number = rsp_face_ff;
   assign rsp_last_face   = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   `MFCE_ASSERT_NEXT(a_face_count_step, clock, reset, emit,
      face_counter_ff == $past(face_counter_ff) + 32'd1, "face counter did not step by one")
   `MFCE_ASSERT_IMPL(a_capture_window, clock, reset, cap_valid_ff,
      state_ff == ST_READ || state_ff == ST_SETTLE, "corner capture outside read phase")
   `MFCE_ASSERT_IMPL(a_read_bound, clock, reset, state_ff == ST_READ,
      rd_idx_ff <= mfce_pkg::corner_last(etype_ff), "corner read beyond element")
   `MFCE_ASSERT_IMPL(a_face_bound, clock, reset, emit,
      face_idx_ff <= mfce_pkg::face_last(etype_ff), "face issued beyond element")

endmodule
